FILE: rtl/csdf_pkg.sv
// Shared types and constants for the chunked stream deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package csdf_pkg;

    localparam int CHUNK_CAPACITY = 4096;
    localparam int REMAIN_W       = $clog2(CHUNK_CAPACITY + 1);
    localparam int MAXLEN_W       = 13;
    localparam int CODE_W         = 32;
    localparam int CFG_IDX_W      = 2;

    typedef enum logic [2:0] {
        KIND_BYTE   = 3'd0,
        KIND_CHUNK  = 3'd1,
        KIND_STREAM = 3'd2,
        KIND_BADLEN = 3'd3,
        KIND_BADCMD = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EOB_CODE = 2'd0,
        REG_EOF_CODE = 2'd1,
        REG_MAX_LEN  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                 vld;
        logic [CFG_IDX_W-1:0] idx;
        logic [CODE_W-1:0]    data;
    } t_cfg_wr;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        t_kind      kind;
    } t_res;

endpackage
`default_nettype wire

FILE: rtl/csdf_parser.sv
// Frame parser: config registers, phase sequencer, word assembly, length and command checks.
// Depends on csdf_pkg; produces at most one result per accepted byte.
`timescale 1ns / 1ps
`default_nettype none
module csdf_parser (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire csdf_pkg::t_cfg_wr  i_cfg,
    input  wire                     i_vld,
    input  wire  [7:0]              i_byte,
    output csdf_pkg::t_res          o_res
);
    import csdf_pkg::*;

    typedef enum logic [2:0] {
        PH_LENGTH, PH_PAYLOAD, PH_COMMAND, PH_TRAILER, PH_DONE, PH_HALT
    } t_phase;

    logic [CODE_W-1:0]   r_eob_code;
    logic [CODE_W-1:0]   r_eof_code;
    logic [MAXLEN_W-1:0] r_max_len;

    t_phase              r_phase, n_phase;
    logic [1:0]          r_idx, n_idx;
    logic [23:0]         r_word, n_word;
    logic [REMAIN_W-1:0] r_remain, n_remain;

    logic [CODE_W-1:0]   w_word;
    logic                w_last;
    logic                w_len_ok;

    assign w_word   = {r_word, i_byte};
    assign w_last   = (r_idx == 2'd3);
    assign w_len_ok = (w_word != '0)
                   && (w_word <= {{(CODE_W-MAXLEN_W){1'b0}}, r_max_len})
                   && (w_word <= CODE_W'(CHUNK_CAPACITY));

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_word     = r_word;
        n_remain   = r_remain;
        o_res.vld  = 1'b0;
        o_res.data = 8'd0;
        o_res.kind = KIND_BYTE;
        if (i_vld) begin
            case (r_phase)
                PH_LENGTH, PH_COMMAND, PH_TRAILER: begin
                    n_word = w_word[23:0];
                    n_idx  = r_idx + 2'd1;
                    if (w_last) begin
                        n_word = '0;
                        case (r_phase)
                            PH_LENGTH: begin
                                if (w_len_ok) begin
                                    n_remain = REMAIN_W'(w_word);
                                    n_phase  = PH_PAYLOAD;
                                end else begin
                                    n_phase    = PH_HALT;
                                    o_res.vld  = 1'b1;
                                    o_res.kind = KIND_BADLEN;
                                end
                            end
                            PH_COMMAND: begin
                                if (w_word == r_eob_code) begin
                                    n_phase    = PH_LENGTH;
                                    o_res.vld  = 1'b1;
                                    o_res.kind = KIND_CHUNK;
                                end else if (w_word == r_eof_code) begin
                                    n_phase = PH_TRAILER;
                                end else begin
                                    n_phase    = PH_HALT;
                                    o_res.vld  = 1'b1;
                                    o_res.kind = KIND_BADCMD;
                                end
                            end
                            default: begin
                                n_phase    = PH_DONE;
                                o_res.vld  = 1'b1;
                                o_res.kind = KIND_STREAM;
                            end
                        endcase
                    end
                end
                PH_PAYLOAD: begin
                    n_remain   = r_remain - REMAIN_W'(1);
                    o_res.vld  = 1'b1;
                    o_res.data = i_byte;
                    o_res.kind = KIND_BYTE;
                    if (r_remain <= REMAIN_W'(1)) begin
                        n_remain = '0;
                        n_phase  = PH_COMMAND;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eob_code <= '0;
            r_eof_code <= CODE_W'(1);
            r_max_len  <= MAXLEN_W'(4096);
            r_phase    <= PH_LENGTH;
            r_idx      <= 2'd0;
            r_word     <= '0;
            r_remain   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_word   <= n_word;
            r_remain <= n_remain;
            if (i_cfg.vld) begin
                case (i_cfg.idx)
                    REG_EOB_CODE: r_eob_code <= i_cfg.data;
                    REG_EOF_CODE: r_eof_code <= i_cfg.data;
                    REG_MAX_LEN:  r_max_len  <= i_cfg.data[MAXLEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_remain != '0))
        else $error("payload phase with zero remaining");

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HALT) |=> (r_phase == PH_HALT))
        else $error("left halt without reset");

    a_byte_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.vld && o_res.kind == KIND_BYTE) |-> (r_phase == PH_PAYLOAD))
        else $error("payload byte outside payload phase");

    a_word_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_idx == 2'd0 && r_word == '0))
        else $error("word assembler not cleared during payload");

endmodule
`default_nettype wire

FILE: rtl/csdf_out_buf.sv
// Two-entry output buffer: result register plus skid stage for the master side.
// Depends on csdf_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none
module csdf_out_buf (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire csdf_pkg::t_res  i_res,
    output logic                 o_ready,
    output logic                 o_vld,
    output logic [7:0]           o_data,
    output csdf_pkg::t_kind      o_kind,
    input  wire                  i_ready
);
    import csdf_pkg::*;

    logic       r_main_vld;
    logic       r_skid_vld;
    logic [7:0] r_main_data, r_skid_data;
    t_kind      r_main_kind, r_skid_kind;
    logic       w_pop;

    assign w_pop   = r_main_vld && i_ready;
    assign o_ready = !r_skid_vld;
    assign o_vld   = r_main_vld;
    assign o_data  = r_main_data;
    assign o_kind  = r_main_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_res.vld) begin
            if (!r_main_vld || w_pop) begin
                r_main_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_pop) begin
                r_main_data <= r_skid_data;
                r_main_kind <= r_skid_kind;
            end
        end else if (i_res.vld) begin
            if (!r_main_vld || w_pop) begin
                r_main_data <= i_res.data;
                r_main_kind <= i_res.kind;
            end else begin
                r_skid_data <= i_res.data;
                r_skid_kind <= i_res.kind;
            end
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_main_vld)
        else $error("skid entry without main entry");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_ready) |=> (r_skid_vld && $stable(r_skid_data)))
        else $error("skid entry lost while stalled");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> !i_res.vld)
        else $error("result pushed into full buffer");

endmodule
`default_nettype wire

FILE: rtl/chunked_stream_deframer_core.sv
// Top level of the chunked stream deframer: ties the parser to the output buffer.
// Depends on csdf_pkg, csdf_parser and csdf_out_buf.
//
// Usage:
//   Slave stream (i_s_*): one framed byte per request. Each chunk is a 4-byte
//   big-endian length, that many payload bytes, then a 4-byte command word.
//   Master stream (o_m_*): tdata carries the payload byte (zero for non-byte
//   kinds), tuser the kind: payload byte, chunk ended, stream ended, bad
//   length, bad command. A bad command after a chunk means drop that chunk.
//   Config channel (i_cfg_*): index 0 end-of-buffer code, 1 end-of-file code,
//   2 maximum chunk length; always ready, write only while idle.
// Throughput: one byte per cycle while tready is high, set by the phase sequencer.
// Output: each result from the combinational parser is registered in the output
//   buffer before it is presented on the master side.
// Stall: a two-entry output buffer keeps tready high through one stalled
//   result; tready drops only when both entries hold results.
// Reset: synchronous, active low; clears phase, counters and buffer, and loads
//   the register defaults 0, 1 and 4096. After a bad length or command the
//   block halts and drops all bytes until reset.
`timescale 1ns / 1ps
`default_nettype none
module chunked_stream_deframer_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    input  wire  [7:0]                     i_s_tdata,   // [7:0] in_byte
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    output logic [7:0]                     o_m_tdata,   // [7:0] out_byte
    output logic [2:0]                     o_m_tuser,   // [2:0] kind
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [csdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [csdf_pkg::CODE_W-1:0]    i_cfg_data
);
    import csdf_pkg::*;

    t_cfg_wr w_cfg;
    t_res    w_res;
    t_kind   w_kind;
    logic    w_accept;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.vld   = i_cfg_valid;
    assign w_cfg.idx   = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_m_tuser   = w_kind;

    csdf_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_vld   (w_accept),
        .i_byte  (i_s_tdata),
        .o_res   (w_res)
    );

    csdf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .o_ready (o_s_tready),
        .o_vld   (o_m_tvalid),
        .o_data  (o_m_tdata),
        .o_kind  (w_kind),
        .i_ready (i_m_tready)
    );

endmodule
`default_nettype wire
